>>> src/nms_pkg.sv
// Shared types and constants for the box non-max suppression block.
`timescale 1ns / 1ps
package nms_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [15:0] CONF_RESET = 16'd39322;
  localparam logic [15:0] IOU_RESET  = 16'd19661;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONF = 2'd0;
  localparam logic [1:0] CFG_IOU  = 2'd1;

  typedef struct packed {
    logic [15:0] y_max;
    logic [15:0] x_max;
    logic [15:0] y_min;
    logic [15:0] x_min;
  } box_t;

  localparam int BOX_W   = $bits(box_t);
  localparam int SCORE_W = 32;
  localparam int AREA_W  = 34;
  localparam int IDX_W   = 6;

  // Overlap verdict returned by the IoU unit
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             hit;
  } iou_res_t;

endpackage

>>> src/nms_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module nms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> src/nms_iou.sv
// Pipelined IoU threshold test of one candidate box against the selected box.
`timescale 1ns / 1ps
module nms_iou (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [nms_pkg::IDX_W-1:0]        in_idx,
  input  nms_pkg::box_t                    box_a,
  input  logic signed [nms_pkg::AREA_W-1:0] area_a,
  input  nms_pkg::box_t                    box_b,
  input  logic [15:0]                      thr,
  output nms_pkg::iou_res_t                res_r,
  output logic                             busy
);

  // Stage 1: intersection edges and candidate extents
  logic                      s1_vld_r;
  logic [nms_pkg::IDX_W-1:0] s1_idx_r;
  logic [15:0]               s1_w_r, s1_h_r;
  logic signed [16:0]        s1_dx_r, s1_dy_r;
  logic [15:0]               x1, y1, x2, y2;

  always_comb begin
    x1 = (box_a.x_min > box_b.x_min) ? box_a.x_min : box_b.x_min;
    y1 = (box_a.y_min > box_b.y_min) ? box_a.y_min : box_b.y_min;
    x2 = (box_a.x_max < box_b.x_max) ? box_a.x_max : box_b.x_max;
    y2 = (box_a.y_max < box_b.y_max) ? box_a.y_max : box_b.y_max;
  end

  // Stage 2: intersection and candidate area
  logic                             s2_vld_r;
  logic [nms_pkg::IDX_W-1:0]        s2_idx_r;
  logic [31:0]                      s2_inter_r;
  logic signed [nms_pkg::AREA_W-1:0] s2_area_r;

  // Stage 3: union
  logic                      s3_vld_r;
  logic [nms_pkg::IDX_W-1:0] s3_idx_r;
  logic [31:0]               s3_inter_r;
  logic                      s3_pos_r;
  logic [33:0]               s3_uni_r;
  logic signed [35:0]        uni;

  always_comb begin
    uni = {{2{area_a[nms_pkg::AREA_W-1]}}, area_a}
        + {{2{s2_area_r[nms_pkg::AREA_W-1]}}, s2_area_r}
        - $signed({4'b0000, s2_inter_r});
  end

  // Stage 4: threshold times union, split in two partial products
  logic                      s4_vld_r;
  logic [nms_pkg::IDX_W-1:0] s4_idx_r;
  logic [31:0]               s4_inter_r;
  logic                      s4_pos_r;
  logic [32:0]               s4_plo_r, s4_phi_r;
  logic [50:0]               rhs;
  logic [50:0]               lhs;

  always_comb begin
    rhs = {1'b0, s4_phi_r, 17'd0} + {18'd0, s4_plo_r};
    lhs = {3'd0, s4_inter_r, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      res_r.vld <= s4_vld_r;
    end
    s1_idx_r   <= in_idx;
    s1_w_r     <= (x2 > x1) ? x2 - x1 : 16'd0;
    s1_h_r     <= (y2 > y1) ? y2 - y1 : 16'd0;
    s1_dx_r    <= $signed({1'b0, box_b.x_max}) - $signed({1'b0, box_b.x_min});
    s1_dy_r    <= $signed({1'b0, box_b.y_max}) - $signed({1'b0, box_b.y_min});
    s2_idx_r   <= s1_idx_r;
    s2_inter_r <= {16'd0, s1_w_r} * {16'd0, s1_h_r};
    s2_area_r  <= nms_pkg::AREA_W'(s1_dx_r) * nms_pkg::AREA_W'(s1_dy_r);
    s3_idx_r   <= s2_idx_r;
    s3_inter_r <= s2_inter_r;
    s3_pos_r   <= (uni > 36'sd0);
    s3_uni_r   <= uni[33:0];
    s4_idx_r   <= s3_idx_r;
    s4_inter_r <= s3_inter_r;
    s4_pos_r   <= s3_pos_r;
    s4_plo_r   <= {17'd0, thr} * {16'd0, s3_uni_r[16:0]};
    s4_phi_r   <= {17'd0, thr} * {16'd0, s3_uni_r[33:17]};
    res_r.idx  <= s4_idx_r;
    res_r.hit  <= s4_pos_r && (lhs > rhs);
  end

  assign busy = s1_vld_r | s2_vld_r | s3_vld_r | s4_vld_r | res_r.vld;

endmodule

>>> src/box_non_max_suppression_unit.sv
// Top level of the greedy box non-max suppression block.
`timescale 1ns / 1ps
// Boxes of a frame are taken one per cycle while the block is idle; each
// box scoring above the confidence threshold is written to the box and
// score RAMs (up to MAX_BOXES, further ones set the overflow flag). On the
// frame_end box the sequencer runs greedy selection out of those RAMs: a
// score scan of the N = kept boxes, a fetch of the winner, then an overlap
// pass through the 5-stage IoU pipeline, repeated for each survivor and
// followed by a closing scan, all through the single read port of each
// RAM. No new box is taken until the last result of the frame has been
// loaded into the output register.
module box_non_max_suppression_unit #(
  parameter int MAX_BOXES  = nms_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = nms_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_x_min,
  input  logic [15:0] in_y_min,
  input  logic [15:0] in_x_max,
  input  logic [15:0] in_y_max,
  input  logic [15:0] in_score,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_x_min,
  output logic [15:0] out_y_min,
  output logic [15:0] out_x_max,
  output logic [15:0] out_y_max,
  output logic [15:0] out_score,
  output logic [15:0] out_item_number,
  output logic        out_none_found,
  output logic        out_overflowed,
  output logic        out_last_result
);

  localparam int ADDR_W = $clog2(MAX_BOXES);
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam logic [15:0] CMASK = 16'((17'd1 << COORD_BITS) - 17'd1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_FETCH, ST_AREA, ST_SUPP, ST_EMIT, ST_FINAL
  } state_t;

  state_t             state_r;
  logic [15:0]        conf_r, iou_r;
  logic [CNT_W-1:0]   kept_r;
  logic [15:0]        item_r;
  logic               ovf_r;
  logic [MAX_BOXES-1:0] done_r;
  logic [ADDR_W-1:0]  ix_r;
  logic               issuing_r;
  logic               d_vld_r, d_last_r;
  logic [ADDR_W-1:0]  d_idx_r;
  logic               best_vld_r;
  logic [ADDR_W-1:0]  best_idx_r;
  logic [15:0]        best_score_r, best_item_r;
  nms_pkg::box_t      best_box_r;
  logic signed [nms_pkg::AREA_W-1:0] best_area_r;
  logic               pend_vld_r;
  nms_pkg::box_t      pend_box_r;
  logic [15:0]        pend_score_r, pend_item_r;
  logic               out_valid_r;

  logic               accept, keep, ix_last, out_free, out_load, iou_busy, iou_vld;
  logic [ADDR_W-1:0]  box_raddr;
  nms_pkg::box_t      in_box, box_rdata;
  logic [nms_pkg::SCORE_W-1:0] score_rdata;
  nms_pkg::iou_res_t  iou_res;
  logic [nms_pkg::IDX_W-1:0] iou_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign keep      = (in_score > conf_r) && (kept_r < CNT_W'(MAX_BOXES));
  assign ix_last   = (CNT_W'(ix_r) + CNT_W'(1)) == kept_r;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = out_free &&
                     (((state_r == ST_EMIT) && pend_vld_r) || (state_r == ST_FINAL));
  assign box_raddr = (state_r == ST_DECIDE) ? best_idx_r : ix_r;
  assign iou_vld   = (state_r == ST_SUPP) && d_vld_r && !done_r[d_idx_r];
  assign iou_idx   = nms_pkg::IDX_W'(d_idx_r);

  always_comb begin
    in_box.x_min = in_x_min & CMASK;
    in_box.y_min = in_y_min & CMASK;
    in_box.x_max = in_x_max & CMASK;
    in_box.y_max = in_y_max & CMASK;
  end

  nms_ram #(.WIDTH(nms_pkg::BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk     (clk),
    .we      (accept && keep),
    .waddr   (kept_r[ADDR_W-1:0]),
    .wdata   (in_box),
    .raddr   (box_raddr),
    .rdata_r (box_rdata)
  );

  nms_ram #(.WIDTH(nms_pkg::SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
    .clk     (clk),
    .we      (accept && keep),
    .waddr   (kept_r[ADDR_W-1:0]),
    .wdata   ({item_r, in_score}),
    .raddr   (ix_r),
    .rdata_r (score_rdata)
  );

  nms_iou u_iou (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (iou_vld),
    .in_idx (iou_idx),
    .box_a  (best_box_r),
    .area_a (best_area_r),
    .box_b  (box_rdata),
    .thr    (iou_r),
    .res_r  (iou_res),
    .busy   (iou_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      conf_r      <= nms_pkg::CONF_RESET;
      iou_r       <= nms_pkg::IOU_RESET;
      kept_r      <= '0;
      item_r      <= '0;
      ovf_r       <= 1'b0;
      done_r      <= '0;
      issuing_r   <= 1'b0;
      d_vld_r     <= 1'b0;
      best_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes
      if (cfg_valid) begin
        case (cfg_index)
          nms_pkg::CFG_CONF: conf_r <= cfg_data;
          nms_pkg::CFG_IOU:  iou_r  <= cfg_data;
          default: ;
        endcase
      end

      // Drop a result once the transaction completes
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      // Advance the RAM read sweep
      d_vld_r  <= issuing_r;
      d_idx_r  <= ix_r;
      d_last_r <= ix_last;
      if (issuing_r) begin
        ix_r <= ix_r + ADDR_W'(1);
        if (ix_last) begin
          issuing_r <= 1'b0;
        end
      end

      // Mark boxes the selected box suppresses
      if (iou_res.vld && iou_res.hit) begin
        done_r[ADDR_W'(iou_res.idx)] <= 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            item_r <= item_r + 16'd1;
            if (in_score > conf_r) begin
              if (keep) begin
                kept_r <= kept_r + CNT_W'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end
            if (in_frame_end) begin
              if (kept_r == '0 && !keep) begin
                state_r <= ST_FINAL;
              end else begin
                ix_r       <= '0;
                issuing_r  <= 1'b1;
                best_vld_r <= 1'b0;
                state_r    <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (d_vld_r) begin
            if (!done_r[d_idx_r] &&
                (!best_vld_r || score_rdata[15:0] >= best_score_r)) begin
              best_vld_r   <= 1'b1;
              best_idx_r   <= d_idx_r;
              best_score_r <= score_rdata[15:0];
              best_item_r  <= score_rdata[31:16];
            end
            if (d_last_r) begin
              state_r <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (!best_vld_r) begin
            state_r <= ST_FINAL;
          end else begin
            done_r[best_idx_r] <= 1'b1;
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          best_box_r <= box_rdata;
          state_r    <= ST_AREA;
        end
        ST_AREA: begin
          best_area_r <= nms_pkg::AREA_W'($signed({1'b0, best_box_r.x_max}) -
                                          $signed({1'b0, best_box_r.x_min})) *
                         nms_pkg::AREA_W'($signed({1'b0, best_box_r.y_max}) -
                                          $signed({1'b0, best_box_r.y_min}));
          ix_r      <= '0;
          issuing_r <= 1'b1;
          state_r   <= ST_SUPP;
        end
        ST_SUPP: begin
          if (!issuing_r && !d_vld_r && !iou_busy) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Send the previous survivor; hold the new one until the next scan
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_valid_r     <= 1'b1;
              out_x_min       <= pend_box_r.x_min;
              out_y_min       <= pend_box_r.y_min;
              out_x_max       <= pend_box_r.x_max;
              out_y_max       <= pend_box_r.y_max;
              out_score       <= pend_score_r;
              out_item_number <= pend_item_r;
              out_none_found  <= 1'b0;
              out_overflowed  <= ovf_r;
              out_last_result <= 1'b0;
            end
            pend_vld_r   <= 1'b1;
            pend_box_r   <= best_box_r;
            pend_score_r <= best_score_r;
            pend_item_r  <= best_item_r;
            best_vld_r   <= 1'b0;
            ix_r         <= '0;
            issuing_r    <= 1'b1;
            state_r      <= ST_SCAN;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_x_min       <= pend_vld_r ? pend_box_r.x_min : 16'd0;
            out_y_min       <= pend_vld_r ? pend_box_r.y_min : 16'd0;
            out_x_max       <= pend_vld_r ? pend_box_r.x_max : 16'd0;
            out_y_max       <= pend_vld_r ? pend_box_r.y_max : 16'd0;
            out_score       <= pend_vld_r ? pend_score_r : 16'd0;
            out_item_number <= pend_vld_r ? pend_item_r : 16'd0;
            out_none_found  <= !pend_vld_r;
            out_overflowed  <= ovf_r;
            out_last_result <= 1'b1;
            kept_r          <= '0;
            item_r          <= '0;
            ovf_r           <= 1'b0;
            done_r          <= '0;
            pend_vld_r      <= 1'b0;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/nms_checker.sv
// Port-level checks for the non-max suppression block and their binding.
`timescale 1ns / 1ps
module nms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_frame_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_score,
  input logic [15:0] out_item_number,
  input logic        out_none_found,
  input logic        out_last_result
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) &&
    $stable(out_last_result))
    else $error("result changed while stalled");

  // An empty frame gives one zeroed final result
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |-> out_last_result && out_score == 16'd0 &&
    out_item_number == 16'd0)
    else $error("none_found result malformed");

  // Stop taking boxes after the frame's last box
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_end |=> !in_ready)
    else $error("box taken right after frame end");

endmodule

bind box_non_max_suppression_unit nms_checker u_nms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_frame_end    (in_frame_end),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_score       (out_score),
  .out_item_number (out_item_number),
  .out_none_found  (out_none_found),
  .out_last_result (out_last_result)
);

>>> dv/nms_checker.sv
// Checker for the box non-max suppression block: predicts frame results and compares them.
`timescale 1ns / 1ps
module nms_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_x_min,
  input  logic [15:0] in_y_min,
  input  logic [15:0] in_x_max,
  input  logic [15:0] in_y_max,
  input  logic [15:0] in_score,
  input  logic        in_frame_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_x_min,
  input  logic [15:0] out_y_min,
  input  logic [15:0] out_x_max,
  input  logic [15:0] out_y_max,
  input  logic [15:0] out_score,
  input  logic [15:0] out_item_number,
  input  logic        out_none_found,
  input  logic        out_overflowed,
  input  logic        out_last_result,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [15:0] x_min, y_min, x_max, y_max, score, item_number;
    logic        none_found, overflowed, last_result;
  } survivor_t;

  logic [15:0]   conf_thr, iou_thr;
  nms_pkg::box_t kept_box [64];
  logic [15:0]   kept_score [64];
  logic [15:0]   kept_item [64];
  logic          kept_done [64];
  int            kept_n;
  logic [15:0]   item_cnt;
  logic          ovf;
  survivor_t     survivors_q[$];

  function automatic longint box_area(nms_pkg::box_t b);
    return (longint'(b.x_max) - longint'(b.x_min)) * (longint'(b.y_max) - longint'(b.y_min));
  endfunction

  function automatic bit is_overlap(nms_pkg::box_t a, nms_pkg::box_t b, logic [15:0] thr);
    longint x1, y1, x2, y2, w, h, isect, uni;
    x1 = (a.x_min > b.x_min) ? a.x_min : b.x_min;
    y1 = (a.y_min > b.y_min) ? a.y_min : b.y_min;
    x2 = (a.x_max < b.x_max) ? a.x_max : b.x_max;
    y2 = (a.y_max < b.y_max) ? a.y_max : b.y_max;
    w = (x2 - x1 > 0) ? x2 - x1 : 0;
    h = (y2 - y1 > 0) ? y2 - y1 : 0;
    isect = w * h;
    uni = box_area(a) + box_area(b) - isect;
    if (uni <= 0) return 0;
    return (isect * 65536) > (longint'(thr) * uni);
  endfunction

  // Greedy selection over the stored boxes of the frame
  task automatic select_survivors();
    int best, cnt;
    survivor_t r;
    cnt = 0;
    forever begin
      best = -1;
      for (int i = 0; i < kept_n; i++)
        if (!kept_done[i] && (best < 0 || kept_score[i] >= kept_score[best])) best = i;
      if (best < 0) break;
      kept_done[best] = 1;
      for (int i = 0; i < kept_n; i++)
        if (!kept_done[i] && is_overlap(kept_box[best], kept_box[i], iou_thr))
          kept_done[i] = 1;
      r = '0;
      r.x_min = kept_box[best].x_min;
      r.y_min = kept_box[best].y_min;
      r.x_max = kept_box[best].x_max;
      r.y_max = kept_box[best].y_max;
      r.score = kept_score[best];
      r.item_number = kept_item[best];
      r.overflowed = ovf;
      survivors_q = {survivors_q, r};
      cnt++;
    end
    if (cnt == 0) begin
      r = '0;
      r.none_found = 1;
      r.overflowed = ovf;
      r.last_result = 1;
      survivors_q = {survivors_q, r};
    end else begin
      survivors_q[$].last_result = 1;
    end
    for (int i = 0; i < 64; i++) kept_done[i] = 0;
    kept_n = 0;
    item_cnt = '0;
    ovf = 0;
  endtask

  always @(posedge clk) begin
    survivor_t exp_r, got;
    if (!rst_n) begin
      conf_thr <= nms_pkg::CONF_RESET;
      iou_thr <= nms_pkg::IOU_RESET;
      kept_n = 0;
      item_cnt = '0;
      ovf = 0;
      fail_count <= 0;
      for (int i = 0; i < 64; i++) kept_done[i] = 0;
      survivors_q.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nms_pkg::CFG_CONF) conf_thr <= cfg_data;
        else if (cfg_index == nms_pkg::CFG_IOU) iou_thr <= cfg_data;
      end
      // Store or drop the accepted box
      if (in_valid && in_ready) begin
        if (in_score > conf_thr) begin
          if (kept_n < nms_pkg::MAX_BOXES_DEF) begin
            kept_box[kept_n] = '{y_max: in_y_max, x_max: in_x_max,
                                 y_min: in_y_min, x_min: in_x_min};
            kept_score[kept_n] = in_score;
            kept_item[kept_n] = item_cnt;
            kept_done[kept_n] = 0;
            kept_n++;
          end else ovf = 1;
        end
        item_cnt = item_cnt + 16'd1;
        if (in_frame_end) select_survivors();
      end
      // Compare the result transaction with the oldest expectation
      if (out_valid && out_ready) begin
        got = '{out_x_min, out_y_min, out_x_max, out_y_max, out_score, out_item_number,
                out_none_found, out_overflowed, out_last_result};
        if (survivors_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = survivors_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: result mismatch expected %h actual %h", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = survivors_q.size();
  end

endmodule

>>> dv/tb_top.sv
// Top of the box non-max suppression testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready;
  logic [15:0] in_x_min, in_y_min, in_x_max, in_y_max, in_score;
  logic        in_frame_end;
  logic        out_valid, out_ready;
  logic [15:0] out_x_min, out_y_min, out_x_max, out_y_max, out_score, out_item_number;
  logic        out_none_found, out_overflowed, out_last_result;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_idle_pct;
  longint      cycle_cnt = 0;

  localparam longint CYCLE_LIMIT = 3000000;

  box_non_max_suppression_unit DUT (.*);

  nms_scoreboard checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_box(logic [15:0] x0, y0, x1, y1, sc, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_x_min <= x0; in_y_min <= y0; in_x_max <= x1; in_y_max <= y1;
    in_score <= sc; in_frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random frame, mostly overlapping clusters around a few centers
  task automatic random_frame(int n_boxes);
    logic [15:0] cx, cy, w, h, x0, y0;
    for (int i = 0; i < n_boxes; i++) begin
      if ($urandom_range(9) == 0) begin
        send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), i == n_boxes - 1);
      end else begin
        if (i % 4 == 0) begin
          cx = 16'($urandom); cy = 16'($urandom);
        end
        w = 16'($urandom_range(8000)); h = 16'($urandom_range(8000));
        x0 = cx + 16'($urandom_range(2000)); y0 = cy + 16'($urandom_range(2000));
        send_box(x0, y0, x0 + w, y0 + h,
                 ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom), i == n_boxes - 1);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_valid = 0; cfg_index = nms_pkg::CFG_CONF; cfg_data = '0;
    in_valid = 0; in_frame_end = 0;
    in_x_min = '0; in_y_min = '0; in_x_max = '0; in_y_max = '0; in_score = '0;
    send_idle_pct = 17; recv_idle_pct = 85;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset thresholds, extremes, ties, inverted boxes
    send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_box(16'd100, 16'd100, 16'd200, 16'd200, 16'd39322, 0);
    send_box(16'd300, 16'd300, 16'd100, 16'd100, 16'd50000, 0);
    send_box(16'd10, 16'd10, 16'd20, 16'd20, 16'd39323, 1);
    send_box(16'd1, 16'd1, 16'd2, 16'd2, 16'd0, 1);
    settle();
    write_reg(nms_pkg::CFG_CONF, 16'd0);
    write_reg(nms_pkg::CFG_IOU, 16'd0);
    send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'd5, 0);
    send_box(16'd5, 16'd5, 16'd15, 16'd15, 16'd5, 0);
    send_box(16'd20, 16'd20, 16'd30, 16'd30, 16'd1, 0);
    send_box(16'd5, 16'd5, 16'd5, 16'd5, 16'd9, 1);
    settle();
    write_reg(nms_pkg::CFG_CONF, 16'hFFFF);
    write_reg(nms_pkg::CFG_IOU, 16'hFFFF);
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    settle();
    // Overflow: 66 boxes sent at conf threshold zero, 64 of them kept
    write_reg(nms_pkg::CFG_CONF, 16'd0);
    write_reg(nms_pkg::CFG_IOU, 16'hFFFF);
    for (int i = 0; i < 66; i++)
      send_box(16'(i * 100), 16'd0, 16'(i * 100 + 50), 16'd50, 16'(i + 1), i == 65);
    settle();

    // Random phases with different idling and thresholds
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 17 : 0;
      write_reg(nms_pkg::CFG_CONF, (ph == 2) ? 16'd0 : 16'($urandom_range(40000)));
      write_reg(nms_pkg::CFG_IOU, (ph == 1) ? 16'hFFFF : 16'($urandom));
      for (int f = 0; f < 2; f++) random_frame($urandom_range(2, 18));
      settle();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
